// ===== src/lanc_pkg.sv =====
// Shared types, constants and helpers for the LMS noise canceller.
package lanc_pkg;

  // Weight format: signed 32-bit with 28 fraction bits
  localparam int WEIGHT_W    = 32;
  localparam int WEIGHT_FRAC = 28;

  // Configuration register widths
  localparam int STEP_W     = 16;
  localparam int TAPS_CFG_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_IN_USE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_DRAIN,
    ST_ROUND,
    ST_ERROR,
    ST_OUTPUT,
    ST_UPDATE,
    ST_UPD_DRAIN
  } lanc_state_t;

  // Datapath controls from the sequencer
  typedef struct packed {
    logic load_in;   // latch primary sample, clear accumulator
    logic upd;       // pipeline runs the weight update, not the MAC
    logic s1;        // stage 1 holds read data
    logic s2;        // stage 2 holds a product
    logic round_en;  // round accumulator into y
    logic err_en;    // form saturated error
    logic mue_en;    // form mu * e
  } lanc_ctrl_t;

  // Saturate a 33-bit signed sum to the 32-bit weight range
  function automatic logic signed [WEIGHT_W-1:0] sat_weight(
    input logic signed [WEIGHT_W:0] v
  );
    logic signed [WEIGHT_W-1:0] r;
    if (v[WEIGHT_W] != v[WEIGHT_W-1]) begin
      r = v[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      r = v[WEIGHT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/lanc_hist_ram.sv =====
// Reference delay line held as a ring buffer in a synchronous memory.
module lanc_hist_ram #(
  parameter int TAPS        = 16,
  parameter int SAMPLE_BITS = 16,
  localparam int IDX_W      = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          clear,
  input  logic signed [SAMPLE_BITS-1:0] push_data,
  input  logic                          rd_en,
  input  logic [IDX_W-1:0]              rd_idx,
  output logic signed [SAMPLE_BITS-1:0] rd_data
);

  logic signed [SAMPLE_BITS-1:0] mem [TAPS];
  logic [TAPS-1:0]               vld_r, vld_nxt;
  logic [IDX_W-1:0]              head_r, head_nxt;
  logic [IDX_W:0]                addr_sum;
  logic [IDX_W-1:0]              rd_addr;
  logic signed [SAMPLE_BITS-1:0] q_r;
  logic                          qv_r;

  // Newest entry sits one below the old head
  assign head_nxt = (head_r == '0) ? IDX_W'(TAPS - 1) : head_r - 1'b1;

  // Logical tap j lives at head + j, wrapped
  assign addr_sum = {1'b0, head_r} + {1'b0, rd_idx};
  assign rd_addr  = (addr_sum >= (IDX_W+1)'(TAPS)) ? IDX_W'(addr_sum - (IDX_W+1)'(TAPS))
                                                   : addr_sum[IDX_W-1:0];

  always_comb begin
    vld_nxt = clear ? '0 : vld_r;
    vld_nxt[head_nxt] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      head_r <= '0;
    end else if (push) begin
      vld_r  <= vld_nxt;
      head_r <= head_nxt;
    end
  end

  // Memory array, one write and one registered read
  always_ff @(posedge clk) begin
    if (push) begin
      mem[head_nxt] <= push_data;
    end
    if (rd_en) begin
      q_r  <= mem[rd_addr];
      qv_r <= vld_r[rd_addr];
    end
  end

  // Entries never written since a clear read as zero
  assign rd_data = qv_r ? q_r : '0;

endmodule

// ===== src/lanc_weight_ram.sv =====
// Tap weight memory with per-entry valid bits for clearing.
module lanc_weight_ram #(
  parameter int TAPS   = 16,
  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 clear,
  input  logic                                 wr_en,
  input  logic [IDX_W-1:0]                     wr_idx,
  input  logic signed [lanc_pkg::WEIGHT_W-1:0] wr_data,
  input  logic                                 rd_en,
  input  logic [IDX_W-1:0]                     rd_idx,
  output logic signed [lanc_pkg::WEIGHT_W-1:0] rd_data
);

  logic signed [lanc_pkg::WEIGHT_W-1:0] mem [TAPS];
  logic [TAPS-1:0]                      vld_r;
  logic signed [lanc_pkg::WEIGHT_W-1:0] q_r;
  logic                                 qv_r;

  // Valid bits: clear at start of run, set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clear) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      q_r  <= mem[rd_idx];
      qv_r <= vld_r[rd_idx];
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

// ===== src/lanc_datapath.sv =====
// MAC, error and weight update arithmetic; MAC and update share one multiplier.
module lanc_datapath #(
  parameter int TAPS        = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  lanc_pkg::lanc_ctrl_t                 ctrl,
  input  logic [lanc_pkg::STEP_W-1:0]          step_size,
  input  logic signed [SAMPLE_BITS-1:0]        primary_sample,
  input  logic signed [lanc_pkg::WEIGHT_W-1:0] w_rd,
  input  logic signed [SAMPLE_BITS-1:0]        x_rd,
  output logic signed [SAMPLE_BITS-1:0]        err,
  output logic signed [lanc_pkg::WEIGHT_W-1:0] w_new
);

  localparam int WW         = lanc_pkg::WEIGHT_W;
  localparam int WF         = lanc_pkg::WEIGHT_FRAC;
  localparam int MUE_W      = lanc_pkg::STEP_W + 1 + SAMPLE_BITS;
  localparam int A_W        = (MUE_W > WW) ? MUE_W : WW;
  localparam int P_W        = A_W + SAMPLE_BITS;
  localparam int ACC_W      = WW + SAMPLE_BITS + $clog2(TAPS + 1);
  localparam int Y_W        = ACC_W - WF;
  localparam int D_W        = Y_W + 1;
  localparam int UPD_SHIFT  = 2 * SAMPLE_BITS - 15;

  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (WF - 1);
  localparam logic signed [P_W-1:0]   P_RND   = P_W'(1) << (UPD_SHIFT - 1);
  localparam logic signed [D_W-1:0]   E_MAX   = D_W'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [D_W-1:0]   E_MIN   = D_W'(-(2**(SAMPLE_BITS-1)));

  logic signed [SAMPLE_BITS-1:0] d_r;
  logic signed [A_W-1:0]         a_op;
  logic signed [P_W-1:0]         prod_r;
  logic signed [P_W-1:0]         p_rnd;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_rnd;
  logic signed [Y_W-1:0]         y_r;
  logic signed [D_W-1:0]         diff;
  logic signed [SAMPLE_BITS-1:0] e_r;
  logic signed [MUE_W-1:0]       mue_r;
  logic signed [WW-1:0]          w1_r, w2_r, dw_r;
  logic signed [WW:0]            w_sum;

  // Shared multiplier: weight for the MAC, mu*e for the update
  assign a_op  = ctrl.upd ? A_W'(mue_r) : A_W'(w_rd);
  assign p_rnd = prod_r + P_RND;

  // Stage 1: product
  always_ff @(posedge clk) begin
    if (ctrl.s1) begin
      prod_r <= a_op * x_rd;
      w1_r   <= w_rd;
    end
  end

  // Stage 2: accumulate, or round the weight step
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      acc_r <= '0;
    end else if (ctrl.s2 && !ctrl.upd) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctrl.s2 && ctrl.upd) begin
      dw_r <= p_rnd[UPD_SHIFT+WW-1:UPD_SHIFT];
      w2_r <= w1_r;
    end
  end

  // Rounded filter output, then saturated error, then mu*e
  assign acc_rnd = acc_r + ACC_RND;
  assign diff    = D_W'(d_r) - D_W'(y_r);

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      d_r <= primary_sample;
    end
    if (ctrl.round_en) begin
      y_r <= acc_rnd[ACC_W-1:WF];
    end
    if (ctrl.err_en) begin
      if (diff > E_MAX) begin
        e_r <= E_MAX[SAMPLE_BITS-1:0];
      end else if (diff < E_MIN) begin
        e_r <= E_MIN[SAMPLE_BITS-1:0];
      end else begin
        e_r <= diff[SAMPLE_BITS-1:0];
      end
    end
    if (ctrl.mue_en) begin
      mue_r <= $signed({1'b0, step_size}) * e_r;
    end
  end

  // Stage 3: new weight, saturated
  assign w_sum = (WW+1)'(w2_r) + (WW+1)'(dw_r);
  assign w_new = lanc_pkg::sat_weight(w_sum);
  assign err   = e_r;

endmodule

// ===== src/lms_adaptive_noise_canceller_core.sv =====
// Top level: handshakes, configuration, sequencer and state memories.
//
// LMS adaptive noise canceller. Each input word carries a primary and a
// reference sample; one cleaned sample comes back per word. The delay line
// and the tap weights live in two single-port-read memories with a
// registered read. An item makes two passes over the taps in use (k): a MAC
// pass, then a read-modify-write weight update pass, both through one
// shared multiplier. The next item can be taken only once both passes and
// their pipeline fill are done. The result is loaded into an output register
// once the error is known and the register is free, and the update pass
// waits for that; the next word is taken once the update pass has drained,
// even if the result is still waiting. A start of run clears both memories
// at once through valid bits, without a separate clearing pass.
module lms_adaptive_noise_canceller_core #(
  parameter int TAPS        = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_primary_sample,
  input  logic signed [SAMPLE_BITS-1:0]          in_reference_sample,
  input  logic                                   in_start_of_run,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS-1:0]          out_clean_sample,
  // configuration channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lanc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lanc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W = $clog2(TAPS + 1);

  lanc_pkg::lanc_state_t state_r, state_nxt;
  lanc_pkg::lanc_ctrl_t  ctrl;

  logic [lanc_pkg::STEP_W-1:0]     step_size_r;
  logic [lanc_pkg::TAPS_CFG_W-1:0] taps_r;
  logic [CNT_W-1:0]                k_r, k_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]                idx1_r, idx2_r, idx3_r;
  logic                            out_valid_r;
  logic signed [SAMPLE_BITS-1:0]   out_clean_sample_r;

  logic                            in_acc;
  logic                            issue;
  logic                            out_load;
  logic                            upd_mode;
  logic                            wr_en;
  logic signed [SAMPLE_BITS-1:0]   x_rd;
  logic signed [lanc_pkg::WEIGHT_W-1:0] w_rd, w_new;
  logic signed [SAMPLE_BITS-1:0]   err;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign upd_mode  = (state_r == lanc_pkg::ST_UPDATE) || (state_r == lanc_pkg::ST_UPD_DRAIN);
  assign wr_en     = v3_r && upd_mode;

  // Effective tap count: zero acts as one, above TAPS acts as TAPS
  always_comb begin
    if (taps_r == '0) begin
      k_nxt = CNT_W'(1);
    end else if (int'(taps_r) > TAPS) begin
      k_nxt = CNT_W'(TAPS);
    end else begin
      k_nxt = CNT_W'(taps_r);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= lanc_pkg::STEP_W'(655);
      taps_r      <= lanc_pkg::TAPS_CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lanc_pkg::CFG_STEP_SIZE:   step_size_r <= cfg_data[lanc_pkg::STEP_W-1:0];
        lanc_pkg::CFG_TAPS_IN_USE: taps_r      <= cfg_data[lanc_pkg::TAPS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state and controls
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    ctrl      = '0;
    ctrl.upd  = upd_mode;
    ctrl.s1   = v1_r;
    ctrl.s2   = v2_r;
    case (state_r)
      lanc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = lanc_pkg::ST_MAC;
        end
      end
      lanc_pkg::ST_MAC: begin
        issue   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == k_r - 1'b1) begin
          state_nxt = lanc_pkg::ST_MAC_DRAIN;
        end
      end
      lanc_pkg::ST_MAC_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = lanc_pkg::ST_ROUND;
        end
      end
      lanc_pkg::ST_ROUND: begin
        ctrl.round_en = 1'b1;
        state_nxt     = lanc_pkg::ST_ERROR;
      end
      lanc_pkg::ST_ERROR: begin
        ctrl.err_en = 1'b1;
        state_nxt   = lanc_pkg::ST_OUTPUT;
      end
      lanc_pkg::ST_OUTPUT: begin
        ctrl.mue_en = 1'b1;
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = lanc_pkg::ST_UPDATE;
        end
      end
      lanc_pkg::ST_UPDATE: begin
        issue   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == k_r - 1'b1) begin
          state_nxt = lanc_pkg::ST_UPD_DRAIN;
        end
      end
      lanc_pkg::ST_UPD_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = lanc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lanc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lanc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tap counter, effective tap count and read pipeline tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      k_r   <= CNT_W'(1);
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        k_r <= k_nxt;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= cnt_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_clean_sample_r <= err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_clean_sample = out_clean_sample_r;

  lanc_hist_ram #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .clear     (in_start_of_run),
    .push_data (in_reference_sample),
    .rd_en     (issue),
    .rd_idx    (cnt_r[IDX_W-1:0]),
    .rd_data   (x_rd)
  );

  lanc_weight_ram #(
    .TAPS (TAPS)
  ) u_weights (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (in_acc && in_start_of_run),
    .wr_en   (wr_en),
    .wr_idx  (idx3_r),
    .wr_data (w_new),
    .rd_en   (issue),
    .rd_idx  (cnt_r[IDX_W-1:0]),
    .rd_data (w_rd)
  );

  lanc_datapath #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .ctrl           (ctrl),
    .step_size      (step_size_r),
    .primary_sample (in_primary_sample),
    .w_rd           (w_rd),
    .x_rd           (x_rd),
    .err            (err),
    .w_new          (w_new)
  );

endmodule
